// ===== design/sexpr_tokenizer_assert.svh =====
// Assertion macros used by the tokenizer top module.
`ifndef SEXPR_TOKENIZER_ASSERT_SVH
`define SEXPR_TOKENIZER_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define STZ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition in one cycle is followed by an expression in the next.
`define STZ_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

// ===== design/stz_pkg.sv =====
// Types, character codes and scan mode codes shared by the tokenizer modules.
`default_nettype none

package stz_pkg;

    localparam int MaxTokenLen = 255;
    localparam int MaxDepth    = 255;

    localparam int NumOps = 4;
    localparam int IdxW   = $clog2(NumOps);
    localparam int CntW   = $clog2(NumOps + 1);

    localparam logic [1:0] ModeStart   = 2'd0;
    localparam logic [1:0] ModeBlock   = 2'd1;
    localparam logic [1:0] ModeComment = 2'd2;

    localparam logic [7:0] ChQuote     = 8'h22;
    localparam logic [7:0] ChLParen    = 8'h28;
    localparam logic [7:0] ChRParen    = 8'h29;
    localparam logic [7:0] ChLBrack    = 8'h5B;
    localparam logic [7:0] ChRBrack    = 8'h5D;
    localparam logic [7:0] ChSlash     = 8'h2F;
    localparam logic [7:0] ChBackslash = 8'h5C;
    localparam logic [7:0] ChNewline   = 8'h0A;

    typedef struct packed {
        logic [1:0] mode;
        logic       pending;
        logic       skip;
        logic       quote;
    } t_ctl;

    typedef struct packed {
        logic       valid;
        logic       is_end;
        logic [7:0] data;
    } t_op;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       trunc;
    } t_res;

endpackage

`default_nettype wire

// ===== design/sexpr_tokenizer.sv =====
// An accepted word is held in the input register, decoded, and its results are loaded into the output buffer.
// Throughput: one input word per cycle while each word yields at most one result and
// the output is ready; a word that yields several results holds the four-entry output buffer
// until its last result is taken. Words that yield no result are consumed without touching the buffer.
// Reset is synchronous, active low, and clears the scan state and empties both buffers.
`default_nettype none

`include "sexpr_tokenizer_assert.svh"

module sexpr_tokenizer #(
    parameter int MAX_TOKEN_LEN = stz_pkg::MaxTokenLen,
    parameter int MAX_DEPTH     = stz_pkg::MaxDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_end_of_input,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_kind,
    output logic [7:0]      o_token_byte,
    output logic            o_truncated,
    output logic            o_last
);

    localparam int LenW   = $clog2(MAX_TOKEN_LEN + 1);
    localparam int DepthW = $clog2(MAX_DEPTH + 1);

    logic                                  r_in_valid;
    logic [7:0]                            r_in_byte;
    logic                                  r_in_eoi;

    stz_pkg::t_ctl                         r_ctl;
    stz_pkg::t_ctl                         n_ctl;
    logic [DepthW-1:0]                     r_depth;
    logic [DepthW-1:0]                     n_depth;
    logic [LenW-1:0]                       r_len;
    logic [LenW-1:0]                       n_len;
    logic                                  r_ovf;
    logic                                  n_ovf;

    stz_pkg::t_op  [stz_pkg::NumOps-1:0]   ops;
    stz_pkg::t_res [stz_pkg::NumOps-1:0]   n_res;
    logic [stz_pkg::CntW-1:0]              n_cnt;

    stz_pkg::t_res [stz_pkg::NumOps-1:0]   r_res;
    logic [stz_pkg::CntW-1:0]              r_cnt;
    logic [stz_pkg::IdxW-1:0]              r_idx;

    logic out_take;
    logic can_load;
    logic consume;
    logic load;

    stz_decode #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_decode (
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .i_ctl   (r_ctl),
        .i_depth (r_depth),
        .o_ops   (ops),
        .o_ctl   (n_ctl),
        .o_depth (n_depth)
    );

    stz_token #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_token (
        .i_ops (ops),
        .i_len (r_len),
        .i_ovf (r_ovf),
        .o_len (n_len),
        .o_ovf (n_ovf),
        .o_res (n_res),
        .o_cnt (n_cnt)
    );

    assign o_out_valid  = (r_cnt != '0);
    assign out_take     = o_out_valid && i_out_ready;
    assign o_kind       = r_res[r_idx].kind;
    assign o_token_byte = r_res[r_idx].data;
    assign o_truncated  = r_res[r_idx].trunc;
    assign o_last       = (r_cnt == stz_pkg::CntW'(1));

    assign can_load   = (r_cnt == '0) || (o_last && i_out_ready);
    assign consume    = r_in_valid && (can_load || (n_cnt == '0));
    assign load       = consume && (n_cnt != '0);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_eoi  <= i_end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_depth <= '0;
            r_len   <= '0;
            r_ovf   <= 1'b0;
        end else if (consume) begin
            r_ctl   <= n_ctl;
            r_depth <= n_depth;
            r_len   <= n_len;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (load) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (out_take) begin
            r_cnt <= r_cnt - stz_pkg::CntW'(1);
            r_idx <= r_idx + stz_pkg::IdxW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    `STZ_ASSERT(a_cnt_max, r_cnt <= stz_pkg::CntW'(stz_pkg::NumOps), "result count overflow")
    `STZ_ASSERT(a_depth_max, r_depth <= DepthW'(MAX_DEPTH), "nesting depth above limit")
    `STZ_ASSERT(a_len_max, r_len <= LenW'(MAX_TOKEN_LEN), "token length above limit")
    `STZ_ASSERT(a_slash_start, r_ctl.pending |-> (r_ctl.mode == stz_pkg::ModeStart), "held slash")
    `STZ_ASSERT_NEXT(a_burst_cont, out_take && !o_last, o_out_valid, "result burst broken")
    `STZ_ASSERT_NEXT(a_in_hold, r_in_valid && !consume, r_in_valid, "held word lost")

endmodule

`default_nettype wire

// ===== design/stz_decode.sv =====
// Byte classifier that turns one input word into token operations and the next scan state.
`default_nettype none

module stz_decode #(
    parameter int MAX_DEPTH = stz_pkg::MaxDepth
) (
    input  wire logic [7:0]                              i_byte,
    input  wire logic                                    i_eoi,
    input  wire stz_pkg::t_ctl                           i_ctl,
    input  wire logic [$clog2(MAX_DEPTH + 1)-1:0]        i_depth,
    output stz_pkg::t_op [stz_pkg::NumOps-1:0]           o_ops,
    output stz_pkg::t_ctl                                o_ctl,
    output logic [$clog2(MAX_DEPTH + 1)-1:0]             o_depth
);

    localparam int DepthW = $clog2(MAX_DEPTH + 1);

    function automatic stz_pkg::t_op op_add(input logic [7:0] ch);
        stz_pkg::t_op op;
        op.valid  = 1'b1;
        op.is_end = 1'b0;
        op.data   = ch;
        return op;
    endfunction

    function automatic stz_pkg::t_op op_end();
        stz_pkg::t_op op;
        op.valid  = 1'b1;
        op.is_end = 1'b1;
        op.data   = 8'h00;
        return op;
    endfunction

    logic is_space;
    logic word;

    assign is_space = (i_byte == 8'h20) || (i_byte == 8'h09) || (i_byte == 8'h0A) ||
                      (i_byte == 8'h0B) || (i_byte == 8'h0C) || (i_byte == 8'h0D);

    always_comb begin
        o_ops   = '0;
        o_ctl   = i_ctl;
        o_depth = i_depth;
        word    = 1'b0;
        if (i_eoi) begin
            if (i_ctl.pending) begin
                o_ops[0] = op_add(stz_pkg::ChSlash);
            end
            o_ops[1]      = op_end();
            o_ctl.mode    = stz_pkg::ModeStart;
            o_ctl.pending = 1'b0;
            o_ctl.skip    = 1'b0;
            o_ctl.quote   = 1'b0;
            o_depth       = '0;
        end else if (i_ctl.skip) begin
            o_ctl.skip = 1'b0;
        end else begin
            case (i_ctl.mode)
                stz_pkg::ModeBlock: begin
                    if (i_ctl.quote) begin
                        if (i_byte == stz_pkg::ChQuote) begin
                            o_ops[1]   = op_add(i_byte);
                            o_ops[2]   = op_end();
                            o_ctl.mode = stz_pkg::ModeStart;
                        end else if (i_byte == stz_pkg::ChBackslash) begin
                            o_ctl.skip = 1'b1;
                        end else begin
                            o_ops[1] = op_add(i_byte);
                        end
                    end else if (i_byte == stz_pkg::ChLParen) begin
                        o_ops[1] = op_add(i_byte);
                        if (i_depth < DepthW'(MAX_DEPTH)) begin
                            o_depth = i_depth + DepthW'(1);
                        end
                    end else if (i_byte == stz_pkg::ChRParen) begin
                        o_ops[1] = op_add(i_byte);
                        if (i_depth <= DepthW'(1)) begin
                            o_depth    = '0;
                            o_ops[2]   = op_end();
                            o_ctl.mode = stz_pkg::ModeStart;
                        end else begin
                            o_depth = i_depth - DepthW'(1);
                        end
                    end else begin
                        o_ops[1] = op_add(i_byte);
                    end
                end
                stz_pkg::ModeComment: begin
                    if (i_byte == stz_pkg::ChNewline) begin
                        o_ops[1]   = op_end();
                        o_ctl.mode = stz_pkg::ModeStart;
                    end
                end
                default: begin
                    if (i_ctl.pending) begin
                        o_ctl.pending = 1'b0;
                        if (i_byte == stz_pkg::ChSlash) begin
                            o_ctl.mode = stz_pkg::ModeComment;
                        end else begin
                            o_ops[0] = op_add(stz_pkg::ChSlash);
                            word     = 1'b1;
                        end
                    end else begin
                        word = 1'b1;
                    end
                end
            endcase
        end

        if (word) begin
            if (is_space) begin
                o_ops[1] = op_end();
            end else if (i_byte == stz_pkg::ChBackslash) begin
                o_ctl.skip = 1'b1;
            end else if (i_byte == stz_pkg::ChQuote) begin
                o_ops[1]    = op_add(i_byte);
                o_ctl.mode  = stz_pkg::ModeBlock;
                o_ctl.quote = 1'b1;
                o_depth     = '0;
            end else if (i_byte == stz_pkg::ChLParen) begin
                o_ops[1]    = op_add(i_byte);
                o_ctl.mode  = stz_pkg::ModeBlock;
                o_ctl.quote = 1'b0;
                o_depth     = DepthW'(1);
            end else if ((i_byte == stz_pkg::ChRParen) || (i_byte == stz_pkg::ChLBrack) ||
                         (i_byte == stz_pkg::ChRBrack)) begin
                o_ops[1] = op_end();
                o_ops[2] = op_add(i_byte);
                o_ops[3] = op_end();
            end else if (i_byte == stz_pkg::ChSlash) begin
                o_ctl.pending = 1'b1;
            end else begin
                o_ops[1] = op_add(i_byte);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/stz_token.sv =====
// Token length tracker that applies the operations of one word and packs its results.
`default_nettype none

module stz_token #(
    parameter int MAX_TOKEN_LEN = stz_pkg::MaxTokenLen
) (
    input  wire stz_pkg::t_op [stz_pkg::NumOps-1:0]      i_ops,
    input  wire logic [$clog2(MAX_TOKEN_LEN + 1)-1:0]    i_len,
    input  wire logic                                    i_ovf,
    output logic [$clog2(MAX_TOKEN_LEN + 1)-1:0]         o_len,
    output logic                                         o_ovf,
    output stz_pkg::t_res [stz_pkg::NumOps-1:0]          o_res,
    output logic [stz_pkg::CntW-1:0]                     o_cnt
);

    localparam int LenW = $clog2(MAX_TOKEN_LEN + 1);

    always_comb begin
        logic [LenW-1:0]          len;
        logic                     ovf;
        logic [stz_pkg::CntW-1:0] cnt;
        len   = i_len;
        ovf   = i_ovf;
        cnt   = '0;
        o_res = '0;
        for (int s = 0; s < stz_pkg::NumOps; s++) begin
            if (i_ops[s].valid) begin
                if (i_ops[s].is_end) begin
                    if (len != '0) begin
                        o_res[cnt[stz_pkg::IdxW-1:0]].kind  = 1'b1;
                        o_res[cnt[stz_pkg::IdxW-1:0]].data  = 8'h00;
                        o_res[cnt[stz_pkg::IdxW-1:0]].trunc = ovf;
                        cnt = cnt + stz_pkg::CntW'(1);
                    end
                    len = '0;
                    ovf = 1'b0;
                end else if (len >= LenW'(MAX_TOKEN_LEN)) begin
                    ovf = 1'b1;
                end else begin
                    o_res[cnt[stz_pkg::IdxW-1:0]].kind  = 1'b0;
                    o_res[cnt[stz_pkg::IdxW-1:0]].data  = i_ops[s].data;
                    o_res[cnt[stz_pkg::IdxW-1:0]].trunc = 1'b0;
                    cnt = cnt + stz_pkg::CntW'(1);
                    len = len + LenW'(1);
                end
            end
        end
        o_len = len;
        o_ovf = ovf;
        o_cnt = cnt;
    end

endmodule

`default_nettype wire
